/* design/clcd_pkg.sv */
// Package for the character LCD nibble sequencer: payload structs, codes,
// register defaults and the microcode table. No dependencies.
`default_nettype none

package clcd_pkg;

  // Field widths
  localparam int OpW    = 3;
  localparam int ByteW  = 8;
  localparam int RowW   = 2;
  localparam int ColW   = 5;
  localparam int NibW   = 4;
  localparam int HoldW  = 20;
  localparam int PulseW = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 20;
  localparam int PcW    = 5;

  // Operation codes
  localparam logic [OpW-1:0] OP_INIT   = 3'd0;
  localparam logic [OpW-1:0] OP_CMD    = 3'd1;
  localparam logic [OpW-1:0] OP_CHAR   = 3'd2;
  localparam logic [OpW-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OpW-1:0] OP_HOME   = 3'd4;
  localparam logic [OpW-1:0] OP_CURSOR = 3'd5;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_PULSE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOW   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_POWER  = 2'd3;

  // Register reset values
  localparam logic [PulseW-1:0] PULSE_RST  = 16'd10;
  localparam logic [PulseW-1:0] SETTLE_RST = 16'd100;
  localparam logic [HoldW-1:0]  SLOW_RST   = 20'd2000;
  localparam logic [HoldW-1:0]  POWER_RST  = 20'd40000;

  // Fixed waits and limits
  localparam logic [HoldW-1:0] HOLD_MAX       = 20'hFFFFF;
  localparam logic [HoldW-1:0] STARTUP_WAIT_A = 20'd5000;
  localparam logic [HoldW-1:0] STARTUP_WAIT_B = 20'd150;

  // Command bytes
  localparam logic [ByteW-1:0] CMD_CLEAR   = 8'h01;
  localparam logic [ByteW-1:0] CMD_HOME    = 8'h02;
  localparam logic [ByteW-1:0] CMD_ROW1    = 8'h80;
  localparam logic [ByteW-1:0] CMD_ROW2    = 8'hC0;
  localparam logic [RowW-1:0]  ROW_FIRST   = 2'd1;
  localparam logic [RowW-1:0]  ROW_SECOND  = 2'd2;
  localparam logic [ColW-1:0]  COL_MAX     = 5'd16;

  // Program entry points
  localparam logic [PcW-1:0] PC_INIT = 5'd0;
  localparam logic [PcW-1:0] PC_BYTE = 5'd25;
  localparam logic [PcW-1:0] PC_LAST = 5'd28;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [ByteW-1:0] byte_value;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  column;
  } req_t;

  typedef struct packed {
    logic             reg_select;
    logic             read_write;
    logic             enable_pin;
    logic [NibW-1:0]  nibble;
    logic [HoldW-1:0] hold_units;
    logic             last;
  } res_t;

  typedef enum logic [1:0] {
    NIB_CONST = 2'd0,
    NIB_HIGH  = 2'd1,
    NIB_LOW   = 2'd2
  } nib_sel_t;

  typedef enum logic [1:0] {
    HOLD_POWER  = 2'd0,
    HOLD_PULSE  = 2'd1,
    HOLD_SETTLE = 2'd2
  } hold_sel_t;

  typedef enum logic [2:0] {
    EXTRA_NONE = 3'd0,
    EXTRA_A    = 3'd1,
    EXTRA_B    = 3'd2,
    EXTRA_SLOW = 3'd3,
    EXTRA_REQ  = 3'd4
  } extra_sel_t;

  typedef enum logic {
    SEQ_NEXT = 1'b0,
    SEQ_END  = 1'b1
  } seq_t;

  // One control word
  typedef struct packed {
    logic            en;
    nib_sel_t        nib_sel;
    logic [NibW-1:0] nib_const;
    hold_sel_t       hold_sel;
    extra_sel_t      extra_sel;
    seq_t            seq;
  } ucw_t;

  // Sequencer to datapath: current step and request context
  typedef struct packed {
    logic             valid;
    ucw_t             word;
    logic [ByteW-1:0] byte_value;
    logic             rs;
    logic             slow;
  } step_t;

  function automatic ucw_t uw(input logic en, input nib_sel_t ns,
                              input logic [NibW-1:0] nc, input hold_sel_t hs,
                              input extra_sel_t xs, input seq_t sq);
    ucw_t w;
    w.en        = en;
    w.nib_sel   = ns;
    w.nib_const = nc;
    w.hold_sel  = hs;
    w.extra_sel = xs;
    w.seq       = sq;
    return w;
  endfunction

  // EN-high / EN-low halves of a constant nibble
  function automatic ucw_t hi(input logic [NibW-1:0] nc);
    return uw(1'b1, NIB_CONST, nc, HOLD_PULSE, EXTRA_NONE, SEQ_NEXT);
  endfunction

  function automatic ucw_t lo(input logic [NibW-1:0] nc, input extra_sel_t xs,
                              input seq_t sq);
    return uw(1'b0, NIB_CONST, nc, HOLD_SETTLE, xs, sq);
  endfunction

  // Microcode: init program at 0, shared byte program at PC_BYTE
  function automatic ucw_t ucode(input logic [PcW-1:0] pc);
    ucw_t w;
    case (pc)
      5'd0:  w = uw(1'b0, NIB_CONST, 4'h0, HOLD_POWER, EXTRA_NONE, SEQ_NEXT);
      5'd1:  w = hi(4'h3);
      5'd2:  w = lo(4'h3, EXTRA_A, SEQ_NEXT);
      5'd3:  w = hi(4'h3);
      5'd4:  w = lo(4'h3, EXTRA_B, SEQ_NEXT);
      5'd5:  w = hi(4'h3);
      5'd6:  w = lo(4'h3, EXTRA_NONE, SEQ_NEXT);
      5'd7:  w = hi(4'h2);
      5'd8:  w = lo(4'h2, EXTRA_NONE, SEQ_NEXT);
      // function set 0x28
      5'd9:  w = hi(4'h2);
      5'd10: w = lo(4'h2, EXTRA_NONE, SEQ_NEXT);
      5'd11: w = hi(4'h8);
      5'd12: w = lo(4'h8, EXTRA_NONE, SEQ_NEXT);
      // display on, cursor on 0x0E
      5'd13: w = hi(4'h0);
      5'd14: w = lo(4'h0, EXTRA_NONE, SEQ_NEXT);
      5'd15: w = hi(4'hE);
      5'd16: w = lo(4'hE, EXTRA_NONE, SEQ_NEXT);
      // clear 0x01, slow
      5'd17: w = hi(4'h0);
      5'd18: w = lo(4'h0, EXTRA_NONE, SEQ_NEXT);
      5'd19: w = hi(4'h1);
      5'd20: w = lo(4'h1, EXTRA_SLOW, SEQ_NEXT);
      // entry mode 0x06
      5'd21: w = hi(4'h0);
      5'd22: w = lo(4'h0, EXTRA_NONE, SEQ_NEXT);
      5'd23: w = hi(4'h6);
      5'd24: w = lo(4'h6, EXTRA_NONE, SEQ_END);
      // byte from the request register
      5'd25: w = uw(1'b1, NIB_HIGH, 4'h0, HOLD_PULSE, EXTRA_NONE, SEQ_NEXT);
      5'd26: w = uw(1'b0, NIB_HIGH, 4'h0, HOLD_SETTLE, EXTRA_NONE, SEQ_NEXT);
      5'd27: w = uw(1'b1, NIB_LOW, 4'h0, HOLD_PULSE, EXTRA_NONE, SEQ_NEXT);
      5'd28: w = uw(1'b0, NIB_LOW, 4'h0, HOLD_SETTLE, EXTRA_REQ, SEQ_END);
      default: w = uw(1'b0, NIB_CONST, 4'h0, HOLD_PULSE, EXTRA_NONE, SEQ_END);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/char_lcd_nibble_sequencer_core.sv */
// Character LCD nibble sequencer top level (microsequencer plus datapath);
// depends on clcd_pkg, clcd_useq, clcd_dpath.
// A taken start sets the running flag, and each step is then registered as
// a result. Throughput: one step per cycle from the step counter; a byte
// item gives 4 results and frees start on its final step; init gives 25.
// Results cannot be held off. Sync reset: sequencer idle, default holds.
`default_nettype none

module char_lcd_nibble_sequencer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request side
  input  wire logic                          start,
  input  wire clcd_pkg::req_t                request,
  output logic                               busy,
  // result side: one item per strobe, never stalled
  output logic                               strobe,
  output clcd_pkg::res_t                     result,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [clcd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [clcd_pkg::CfgDataW-1:0] cfg_data
);

  // current microcode word plus the latched request context
  clcd_pkg::step_t step;

  // Decodes the request, picks the program entry (init or byte program)
  // and walks the step counter until a word marked as the end.
  clcd_useq u_useq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .step    (step)
  );

  // Forms the pin levels and the saturated hold for each word and
  // registers them as one result item.
  clcd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

`default_nettype wire

/* design/clcd_useq.sv */
// Microsequencer: request decode, step counter and microcode fetch.
// Depends on clcd_pkg.
`default_nettype none

module clcd_useq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire clcd_pkg::req_t request,
  output logic               busy,
  output clcd_pkg::step_t    step
);

  logic                         running;
  logic [clcd_pkg::PcW-1:0]     pc;
  logic [clcd_pkg::ByteW-1:0]   byte_reg;
  logic                         rs_reg;
  logic                         slow_reg;

  clcd_pkg::ucw_t               word;
  logic                         accept;
  logic                         launch;
  logic [clcd_pkg::PcW-1:0]     entry;
  logic [clcd_pkg::ByteW-1:0]   byte_next;
  logic                         rs_next;
  logic                         slow_next;
  logic                         cursor_ok;
  logic [clcd_pkg::ColW-1:0]    col_m1;

  assign word   = clcd_pkg::ucode(pc);
  // free again during the final step of a program
  assign busy   = running && (word.seq != clcd_pkg::SEQ_END);
  assign accept = start && !busy;

  assign col_m1    = request.column - 5'd1;
  assign cursor_ok = (request.column != 5'd0) && (request.column <= clcd_pkg::COL_MAX) &&
                     ((request.row == clcd_pkg::ROW_FIRST) ||
                      (request.row == clcd_pkg::ROW_SECOND));

  always_comb begin
    launch    = 1'b0;
    entry     = clcd_pkg::PC_BYTE;
    byte_next = request.byte_value;
    rs_next   = 1'b0;
    slow_next = 1'b0;
    case (request.operation)
      clcd_pkg::OP_INIT: begin
        launch = 1'b1;
        entry  = clcd_pkg::PC_INIT;
      end
      clcd_pkg::OP_CMD: begin
        launch = 1'b1;
      end
      clcd_pkg::OP_CHAR: begin
        launch  = 1'b1;
        rs_next = 1'b1;
      end
      clcd_pkg::OP_CLEAR: begin
        launch    = 1'b1;
        byte_next = clcd_pkg::CMD_CLEAR;
        slow_next = 1'b1;
      end
      clcd_pkg::OP_HOME: begin
        launch    = 1'b1;
        byte_next = clcd_pkg::CMD_HOME;
        slow_next = 1'b1;
      end
      clcd_pkg::OP_CURSOR: begin
        launch    = cursor_ok;
        byte_next = ((request.row == clcd_pkg::ROW_FIRST) ? clcd_pkg::CMD_ROW1
                                                           : clcd_pkg::CMD_ROW2) |
                    {4'h0, col_m1[3:0]};
      end
      default: begin
        launch = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= clcd_pkg::PC_INIT;
    end else if (accept && launch) begin
      running <= 1'b1;
      pc      <= entry;
    end else if (running) begin
      if (word.seq == clcd_pkg::SEQ_END) begin
        running <= 1'b0;
      end else begin
        pc <= pc + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && launch) begin
      byte_reg <= byte_next;
      rs_reg   <= rs_next;
      slow_reg <= slow_next;
    end
  end

  assign step.valid      = running;
  assign step.word       = word;
  assign step.byte_value = byte_reg;
  assign step.rs         = rs_reg;
  assign step.slow       = slow_reg;

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    running |-> (pc <= clcd_pkg::PC_LAST))
    else $error("step counter ran past the microcode");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && !launch) |=> !running)
    else $error("rejected item started a program");

  a_end: assert property (@(posedge clk) disable iff (rst)
    (running && (word.seq == clcd_pkg::SEQ_END) && !(accept && launch)) |=> !running)
    else $error("program did not stop at its final step");

endmodule

`default_nettype wire

/* design/clcd_dpath.sv */
// Datapath: configuration registers, pin and hold formation, result register.
// Depends on clcd_pkg.
`default_nettype none

module clcd_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [clcd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [clcd_pkg::CfgDataW-1:0] cfg_data,
  input  wire clcd_pkg::step_t               step,
  output logic                               strobe,
  output clcd_pkg::res_t                     result
);

  logic [clcd_pkg::PulseW-1:0] pulse_units;
  logic [clcd_pkg::PulseW-1:0] settle_units;
  logic [clcd_pkg::HoldW-1:0]  slow_cmd_units;
  logic [clcd_pkg::HoldW-1:0]  power_wait_units;

  logic [clcd_pkg::HoldW-1:0]  base;
  logic [clcd_pkg::HoldW-1:0]  extra;
  logic [clcd_pkg::HoldW:0]    sum;
  logic [clcd_pkg::NibW-1:0]   nib;
  clcd_pkg::res_t              result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_units      <= clcd_pkg::PULSE_RST;
      settle_units     <= clcd_pkg::SETTLE_RST;
      slow_cmd_units   <= clcd_pkg::SLOW_RST;
      power_wait_units <= clcd_pkg::POWER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        clcd_pkg::CFG_PULSE:  pulse_units      <= cfg_data[clcd_pkg::PulseW-1:0];
        clcd_pkg::CFG_SETTLE: settle_units     <= cfg_data[clcd_pkg::PulseW-1:0];
        clcd_pkg::CFG_SLOW:   slow_cmd_units   <= cfg_data;
        clcd_pkg::CFG_POWER:  power_wait_units <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (step.word.hold_sel)
      clcd_pkg::HOLD_POWER:  base = power_wait_units;
      clcd_pkg::HOLD_PULSE:  base = {4'h0, pulse_units};
      clcd_pkg::HOLD_SETTLE: base = {4'h0, settle_units};
      default:               base = {4'h0, pulse_units};
    endcase
    case (step.word.extra_sel)
      clcd_pkg::EXTRA_A:    extra = clcd_pkg::STARTUP_WAIT_A;
      clcd_pkg::EXTRA_B:    extra = clcd_pkg::STARTUP_WAIT_B;
      clcd_pkg::EXTRA_SLOW: extra = slow_cmd_units;
      clcd_pkg::EXTRA_REQ:  extra = step.slow ? slow_cmd_units : '0;
      default:              extra = '0;
    endcase
    case (step.word.nib_sel)
      clcd_pkg::NIB_HIGH: nib = step.byte_value[7:4];
      clcd_pkg::NIB_LOW:  nib = step.byte_value[3:0];
      default:            nib = step.word.nib_const;
    endcase
  end

  assign sum = {1'b0, base} + {1'b0, extra};

  always_comb begin
    result_next.reg_select = (step.word.nib_sel != clcd_pkg::NIB_CONST) && step.rs;
    result_next.read_write = 1'b0;
    result_next.enable_pin = step.word.en;
    result_next.nibble     = nib;
    result_next.hold_units = sum[clcd_pkg::HoldW] ? clcd_pkg::HOLD_MAX
                                                  : sum[clcd_pkg::HoldW-1:0];
    result_next.last       = (step.word.seq == clcd_pkg::SEQ_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_last_low: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |-> !result.enable_pin)
    else $error("item ended on an EN-high step");

  a_pulse_hold: assert property (@(posedge clk) disable iff (rst)
    (step.valid && step.word.en) |=> (result.hold_units == {4'h0, $past(pulse_units)}))
    else $error("EN-high step hold is not the pulse time");

endmodule

`default_nettype wire
